// ===== rtl/bb3_pkg.sv =====
package bb3_pkg;

    localparam int ChanW = 8;
    localparam int PixW  = 3 * ChanW;

    localparam logic [1:0] CfgWidth  = 2'd0;
    localparam logic [1:0] CfgHeight = 2'd1;

    localparam logic ModePixel = 1'b0;
    localparam logic ModeDrain = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [ChanW-1:0] red_in;
        logic [ChanW-1:0] green_in;
        logic [ChanW-1:0] blue_in;
    } t_pix_word;

    typedef struct packed {
        logic [ChanW-1:0] red_out;
        logic [ChanW-1:0] green_out;
        logic [ChanW-1:0] blue_out;
        logic             image_done;
        logic             run_last;
    } t_blur_word;

    // Nine window cells, index row * 3 + column, each packed red, green, blue.
    typedef logic [8:0][PixW-1:0] t_cells;

    typedef struct packed {
        t_cells     cells;
        logic [2:0] row_ok;
        logic [2:0] col_ok;
        logic       image_done;
        logic       run_last;
    } t_job;

endpackage

// ===== rtl/bb3_stream_if.sv =====
interface bb3_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/bb3_line_store.sv =====
module bb3_line_store
    import bb3_pkg::*;
#(
    parameter int Depth = 1024,
    parameter int AddrW = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rd_en,
    input  logic                      i_wr_en,
    input  logic [AddrW-1:0]          i_addr,
    input  logic [PixW-1:0]           i_wr_old,
    input  logic [PixW-1:0]           i_wr_new,
    output logic [PixW-1:0]           o_rd_old,
    output logic [PixW-1:0]           o_rd_new
);

    logic [PixW-1:0] r_mem_old [Depth];
    logic [PixW-1:0] r_mem_new [Depth];
    logic [PixW-1:0] r_rd_old;
    logic [PixW-1:0] r_rd_new;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_old[i_addr] <= i_wr_old;
            r_mem_new[i_addr] <= i_wr_new;
        end
        if (i_rd_en) begin
            r_rd_old <= r_mem_old[i_addr];
            r_rd_new <= r_mem_new[i_addr];
        end
    end

    assign o_rd_old = r_rd_old;
    assign o_rd_new = r_rd_new;

endmodule

// ===== rtl/bb3_average.sv =====
module bb3_average
    import bb3_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    output logic                o_job_ready,
    input  t_job                i_job,
    bb3_stream_if.source        o_blur
);

    localparam int SumW       = 12;
    localparam int CntW       = 4;
    localparam int NumW       = SumW + 1;
    localparam int RecipShift = 18;
    localparam int RecipW     = 18;
    localparam int ProdW      = NumW + RecipW;

    // Rounded half up mean is floor((2*sum + n) / (2*n)); the divide by 2*n is a
    // multiply by a ceiling reciprocal, exact for every numerator below 2**13.
    localparam logic [RecipW-1:0] RecipN1 = RecipW'((2**RecipShift + 1) / 2);
    localparam logic [RecipW-1:0] RecipN2 = RecipW'((2**RecipShift + 3) / 4);
    localparam logic [RecipW-1:0] RecipN3 = RecipW'((2**RecipShift + 5) / 6);
    localparam logic [RecipW-1:0] RecipN4 = RecipW'((2**RecipShift + 7) / 8);
    localparam logic [RecipW-1:0] RecipN6 = RecipW'((2**RecipShift + 11) / 12);
    localparam logic [RecipW-1:0] RecipN9 = RecipW'((2**RecipShift + 17) / 18);

    function automatic logic [RecipW-1:0] f_recip(input logic [CntW-1:0] n);
        logic [RecipW-1:0] rec;
        unique case (n)
            4'd1:    rec = RecipN1;
            4'd2:    rec = RecipN2;
            4'd3:    rec = RecipN3;
            4'd4:    rec = RecipN4;
            4'd6:    rec = RecipN6;
            default: rec = RecipN9;
        endcase
        return rec;
    endfunction

    logic                  r_a_valid;
    logic [2:0][SumW-1:0]  r_a_sum;
    logic [CntW-1:0]       r_a_n;
    logic                  r_a_done;
    logic                  r_a_last;
    logic                  r_b_valid;
    logic [2:0][ProdW-1:0] r_b_prod;
    logic                  r_b_done;
    logic                  r_b_last;
    logic                  r_c_valid;
    t_blur_word            r_c_word;

    logic [2:0][SumW-1:0]  a_sum;
    logic [CntW-1:0]       a_n;
    logic [2:0][ProdW-1:0] b_prod;
    logic [2:0][NumW-1:0]  b_num;
    logic [RecipW-1:0]     b_recip;
    logic                  c_ready;
    logic                  b_ready;
    logic                  a_ready;
    logic                  job_take;

    assign c_ready     = !r_c_valid || o_blur.ready;
    assign b_ready     = !r_b_valid || c_ready;
    assign a_ready     = !r_a_valid || b_ready;
    assign o_job_ready = a_ready;
    assign job_take    = i_job_valid && a_ready;

    always_comb begin
        a_sum = '0;
        a_n   = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (i_job.row_ok[i] && i_job.col_ok[j]) begin
                    for (int ch = 0; ch < 3; ch++) begin
                        a_sum[ch] = a_sum[ch]
                                  + SumW'(i_job.cells[i * 3 + j][ch * ChanW +: ChanW]);
                    end
                    a_n = a_n + CntW'(1);
                end
            end
        end
    end

    always_comb begin
        b_recip = f_recip(r_a_n);
        for (int ch = 0; ch < 3; ch++) begin
            b_num[ch]  = {r_a_sum[ch], 1'b0} + NumW'(r_a_n);
            b_prod[ch] = ProdW'(b_num[ch]) * ProdW'(b_recip);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_job_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
            if (c_ready) begin
                r_c_valid <= r_b_valid;
            end
        end
        if (job_take) begin
            r_a_sum  <= a_sum;
            r_a_n    <= a_n;
            r_a_done <= i_job.image_done;
            r_a_last <= i_job.run_last;
        end
        if (r_a_valid && b_ready) begin
            r_b_prod <= b_prod;
            r_b_done <= r_a_done;
            r_b_last <= r_a_last;
        end
        if (r_b_valid && c_ready) begin
            r_c_word.red_out    <= r_b_prod[2][RecipShift +: ChanW];
            r_c_word.green_out  <= r_b_prod[1][RecipShift +: ChanW];
            r_c_word.blue_out   <= r_b_prod[0][RecipShift +: ChanW];
            r_c_word.image_done <= r_b_done;
            r_c_word.run_last   <= r_b_last;
        end
    end

    assign o_blur.valid = r_c_valid;
    assign o_blur.data  = r_c_word;

endmodule

// ===== rtl/box_blur_3x3_edge_average.sv =====
// Channel   Direction  Word         Handshake
// i_pix     in         t_pix_word   valid/ready
// o_blur    out        t_blur_word  valid/ready
// i_cfg_*   in         16-bit data  write enable only
//
// A pixel is read from its column, written back, then yields one job per result;
// a drain word reads three columns and yields one job. The single read port of each
// row memory sets these steps: a drain needs three reads of it, a pixel one read
// and one write-back. An ignored word is taken straight from idle. Jobs pass the
// a, b and c registers of the averaging pipeline, which fills up and then stalls
// on o_blur. Reset is synchronous; the row memories are not cleared.
module box_blur_3x3_edge_average
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [15:0]   i_cfg_data,
    bb3_stream_if.sink    i_pix,
    bb3_stream_if.source  o_blur
);

    localparam int AddrW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CntW  = $clog2(MAX_WIDTH + 1);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_PIX_RD = 8'b0000_0010,
        ST_PIX_J1 = 8'b0000_0100,
        ST_PIX_J2 = 8'b0000_1000,
        ST_DR_A   = 8'b0001_0000,
        ST_DR_B   = 8'b0010_0000,
        ST_DR_C   = 8'b0100_0000,
        ST_DR_J   = 8'b1000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [CntW-1:0]  r_width, n_width;
    logic [15:0]      r_height, n_height;
    logic [15:0]      r_row, n_row;
    logic [AddrW-1:0] r_col, n_col;
    logic [CntW-1:0]  r_drain, n_drain;
    t_cells           r_win, n_win;
    logic [PixW-1:0]  r_pix, n_pix;
    logic             r_need1, n_need1;
    logic             r_need2, n_need2;
    logic             r_row_top, n_row_top;
    logic             r_col_left2, n_col_left2;
    logic             r_col_left1, n_col_left1;

    logic             accept;
    logic             pix_ok;
    logic             drain_ok;
    logic [CntW-1:0]  col_next;
    logic [CntW-1:0]  drain_next;
    logic [10:0]      cfg_w;
    logic             mem_rd;
    logic             mem_wr;
    logic [AddrW-1:0] mem_addr;
    logic [PixW-1:0]  rd_old;
    logic [PixW-1:0]  rd_new;
    logic             job_valid;
    logic             job_ready;
    t_job             job;

    assign accept     = i_pix.valid && i_pix.ready;
    assign i_pix.ready = (r_state == ST_IDLE);
    assign pix_ok     = (r_row < r_height);
    assign drain_ok   = !pix_ok && (r_drain < r_width);
    assign col_next   = CntW'(r_col) + CntW'(1);
    assign drain_next = r_drain + CntW'(1);
    assign cfg_w      = i_cfg_data[10:0];

    always_comb begin
        n_state     = r_state;
        n_width     = r_width;
        n_height    = r_height;
        n_row       = r_row;
        n_col       = r_col;
        n_drain     = r_drain;
        n_win       = r_win;
        n_pix       = r_pix;
        n_need1     = r_need1;
        n_need2     = r_need2;
        n_row_top   = r_row_top;
        n_col_left2 = r_col_left2;
        n_col_left1 = r_col_left1;
        mem_rd      = 1'b0;
        mem_wr      = 1'b0;
        mem_addr    = r_col;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_pix.data.mode == ModePixel) begin
                        if (pix_ok) begin
                            n_pix   = {i_pix.data.red_in, i_pix.data.green_in,
                                       i_pix.data.blue_in};
                            mem_rd  = 1'b1;
                            n_state = ST_PIX_RD;
                        end
                    end else if (drain_ok) begin
                        mem_rd   = 1'b1;
                        mem_addr = AddrW'(r_drain);
                        n_state  = ST_DR_A;
                    end
                end
            end
            ST_PIX_RD: begin
                for (int i = 0; i < 3; i++) begin
                    n_win[i * 3]     = r_win[i * 3 + 1];
                    n_win[i * 3 + 1] = r_win[i * 3 + 2];
                end
                n_win[2]    = rd_old;
                n_win[5]    = rd_new;
                n_win[8]    = r_pix;
                mem_wr      = 1'b1;
                n_row_top   = (r_row > 16'd1);
                n_col_left2 = (r_col > AddrW'(1));
                n_col_left1 = (r_col != '0);
                n_need1     = (r_row != '0) && (r_col != '0);
                n_need2     = (r_row != '0) && (col_next == r_width);
                if (col_next >= r_width) begin
                    n_col = '0;
                    n_row = r_row + 16'd1;
                end else begin
                    n_col = r_col + AddrW'(1);
                end
                if (n_need1) begin
                    n_state = ST_PIX_J1;
                end else if (n_need2) begin
                    n_state = ST_PIX_J2;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PIX_J1: begin
                if (job_ready) begin
                    n_state = r_need2 ? ST_PIX_J2 : ST_IDLE;
                end
            end
            ST_PIX_J2: begin
                if (job_ready) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DR_A: begin
                n_win[1] = rd_old;
                n_win[4] = rd_new;
                mem_rd   = 1'b1;
                mem_addr = AddrW'(r_drain - CntW'(1));
                n_state  = ST_DR_B;
            end
            ST_DR_B: begin
                n_win[0] = rd_old;
                n_win[3] = rd_new;
                mem_rd   = 1'b1;
                mem_addr = AddrW'(drain_next);
                n_state  = ST_DR_C;
            end
            ST_DR_C: begin
                n_win[2] = rd_old;
                n_win[5] = rd_new;
                n_state  = ST_DR_J;
            end
            ST_DR_J: begin
                if (job_ready) begin
                    n_state = ST_IDLE;
                    if (drain_next >= r_width) begin
                        n_row   = '0;
                        n_col   = '0;
                        n_drain = '0;
                        n_win   = '0;
                    end else begin
                        n_drain = drain_next;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // A register write restarts the image.
        if (i_cfg_we && (i_cfg_idx == CfgWidth || i_cfg_idx == CfgHeight)) begin
            if (i_cfg_idx == CfgWidth) begin
                if (cfg_w == '0) begin
                    n_width = CntW'(1);
                end else if (32'(cfg_w) > 32'(MAX_WIDTH)) begin
                    n_width = CntW'(MAX_WIDTH);
                end else begin
                    n_width = CntW'(cfg_w);
                end
            end else begin
                n_height = (i_cfg_data == '0) ? 16'd1 : i_cfg_data;
            end
            n_row   = '0;
            n_col   = '0;
            n_drain = '0;
            n_win   = '0;
        end
    end

    always_comb begin
        job       = '0;
        job_valid = 1'b0;
        unique case (r_state)
            ST_PIX_J1: begin
                job_valid    = 1'b1;
                job.cells    = r_win;
                job.row_ok   = {2'b11, r_row_top};
                job.col_ok   = {2'b11, r_col_left2};
                job.run_last = !r_need2;
            end
            ST_PIX_J2: begin
                job_valid = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    job.cells[i * 3]     = r_win[i * 3 + 1];
                    job.cells[i * 3 + 1] = r_win[i * 3 + 2];
                end
                job.row_ok   = {2'b11, r_row_top};
                job.col_ok   = {2'b01, r_col_left1};
                job.run_last = 1'b1;
            end
            ST_DR_J: begin
                job_valid      = 1'b1;
                job.cells      = r_win;
                job.row_ok     = {2'b01, (r_height > 16'd1)};
                job.col_ok     = {(drain_next < r_width), 1'b1, (r_drain != '0)};
                job.image_done = (drain_next == r_width);
                job.run_last   = 1'b1;
            end
            default: begin
                job_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_width  <= CntW'(1);
            r_height <= 16'd1;
            r_row    <= '0;
            r_col    <= '0;
            r_drain  <= '0;
            r_win    <= '0;
        end else begin
            r_state  <= n_state;
            r_width  <= n_width;
            r_height <= n_height;
            r_row    <= n_row;
            r_col    <= n_col;
            r_drain  <= n_drain;
            r_win    <= n_win;
        end
        r_pix       <= n_pix;
        r_need1     <= n_need1;
        r_need2     <= n_need2;
        r_row_top   <= n_row_top;
        r_col_left2 <= n_col_left2;
        r_col_left1 <= n_col_left1;
    end

    bb3_line_store #(
        .Depth (MAX_WIDTH),
        .AddrW (AddrW)
    ) u_line_store (
        .i_clk    (i_clk),
        .i_rd_en  (mem_rd),
        .i_wr_en  (mem_wr),
        .i_addr   (mem_addr),
        .i_wr_old (rd_new),
        .i_wr_new (r_pix),
        .o_rd_old (rd_old),
        .o_rd_new (rd_new)
    );

    bb3_average u_average (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job       (job),
        .o_blur      (o_blur)
    );

`ifndef SYNTHESIS
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_rd && mem_wr))
        else $error("Row memory read and written in the same cycle.");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CntW'(r_col) < r_width)
        else $error("Column position has reached the image width.");

    a_drain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain < r_width)
        else $error("Drain position has reached the image width.");

    a_pixel_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_pix.data.mode == ModePixel && pix_ok && !i_cfg_we)
        |=> (r_state == ST_PIX_RD))
        else $error("Accepted pixel word did not start a row memory read.");
`endif

endmodule
